[rtl/core/mbr_pkg.sv]
// Shared types and constants for the mesh bounds and radii block.
`timescale 1ns / 1ps
`default_nettype none

package mbr_pkg;

	// Back end control states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROOT,
		BK_FIN
	} bk_state_t;

	// 10000*s >= (100r+1)^2 with s = r^2 + rem reduces to RND_SCALE*rem > r
	localparam int RND_SCALE = 50;

	// Snapshot layout: six box bounds, then the two squares (2*cb each)
	function automatic int snap_bits(input int cb);
		return 10 * cb;
	endfunction

endpackage

`default_nettype wire

[rtl/core/mbr_front.sv]
// Front end: squares pipeline and running box / square accumulators.
`timescale 1ns / 1ps
`default_nettype none

module mbr_front #(
	parameter int CB = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [CB-1:0]                coord_x,
	input  logic signed [CB-1:0]                coord_y,
	input  logic signed [CB-1:0]                coord_z,
	input  logic                                last_vertex,
	input  logic                                in_valid,
	output logic                                in_ready,
	output logic                                snap_push,
	output logic [mbr_pkg::snap_bits(CB)-1:0]   snap_data,
	input  logic                                snap_full
);
	import mbr_pkg::*;

	localparam int SW = 2 * CB;
	localparam logic signed [CB-1:0] MAXV = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] MINV = {1'b1, {(CB-1){1'b0}}};

	logic                 adv;
	logic signed [SW-1:0] sq_x, sq_y, sq_z;

	logic                 v_s1, last_s1;
	logic signed [CB-1:0] x_s1, y_s1, z_s1;
	logic [SW-1:0]        xx_s1, yy_s1, zz_s1;

	logic                 v_s2, last_s2;
	logic signed [CB-1:0] x_s2, y_s2, z_s2;
	logic [SW-1:0]        across_s2, whole_s2;

	logic signed [CB-1:0] least_x_q, most_x_q, least_y_q, most_y_q, least_z_q, most_z_q;
	logic [SW-1:0]        wide_q, far_q;

	logic signed [CB-1:0] nlx, nmx, nly, nmy, nlz, nmz;
	logic [SW-1:0]        nwide, nfar;

	// only a finished mesh blocked by a full queue holds the pipe
	assign adv      = !(v_s2 && last_s2 && snap_full);
	assign in_ready = adv;

	assign sq_x = SW'(coord_x) * SW'(coord_x);
	assign sq_y = SW'(coord_y) * SW'(coord_y);
	assign sq_z = SW'(coord_z) * SW'(coord_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1      <= coord_x;
			y_s1      <= coord_y;
			z_s1      <= coord_z;
			last_s1   <= last_vertex;
			xx_s1     <= sq_x;
			yy_s1     <= sq_y;
			zz_s1     <= sq_z;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			z_s2      <= z_s1;
			last_s2   <= last_s1;
			across_s2 <= xx_s1 + zz_s1;
			whole_s2  <= xx_s1 + yy_s1 + zz_s1;
		end
	end

	always_comb begin
		nlx   = (x_s2 < least_x_q) ? x_s2 : least_x_q;
		nmx   = (x_s2 > most_x_q)  ? x_s2 : most_x_q;
		nly   = (y_s2 < least_y_q) ? y_s2 : least_y_q;
		nmy   = (y_s2 > most_y_q)  ? y_s2 : most_y_q;
		nlz   = (z_s2 < least_z_q) ? z_s2 : least_z_q;
		nmz   = (z_s2 > most_z_q)  ? z_s2 : most_z_q;
		nwide = (across_s2 > wide_q) ? across_s2 : wide_q;
		nfar  = (whole_s2 > far_q)   ? whole_s2  : far_q;
	end

	assign snap_push = v_s2 && last_s2 && !snap_full;
	assign snap_data = {nlx, nmx, nly, nmy, nlz, nmz, nwide, nfar};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_x_q <= MAXV;
			most_x_q  <= MINV;
			least_y_q <= MAXV;
			most_y_q  <= MINV;
			least_z_q <= MAXV;
			most_z_q  <= MINV;
			wide_q    <= '0;
			far_q     <= '0;
		end else if (v_s2 && adv) begin
			if (last_s2) begin
				least_x_q <= MAXV;
				most_x_q  <= MINV;
				least_y_q <= MAXV;
				most_y_q  <= MINV;
				least_z_q <= MAXV;
				most_z_q  <= MINV;
				wide_q    <= '0;
				far_q     <= '0;
			end else begin
				least_x_q <= nlx;
				most_x_q  <= nmx;
				least_y_q <= nly;
				most_y_q  <= nmy;
				least_z_q <= nlz;
				most_z_q  <= nmz;
				wide_q    <= nwide;
				far_q     <= nfar;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/mbr_queue.sv]
// Two-entry queue of finished mesh snapshots between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module mbr_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int DEPTH = 2;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic          wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	// the user must push only when not full and pop only when not empty; the queue does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

[rtl/core/mbr_isqrt.sv]
// Iterative integer square root, one root bit per cycle, with remainder.
`timescale 1ns / 1ps
`default_nettype none

module mbr_isqrt #(
	parameter int CB = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*CB-1:0] sq,
	output logic [CB-1:0]   root,
	output logic [CB+1:0]   rem,
	output logic            done
);
	localparam int SW = 2 * CB;
	localparam int NW = $clog2(CB + 1);

	logic [SW-1:0] sh_q;
	logic [CB+1:0] rem_q;
	logic [CB-1:0] root_q;
	logic [NW-1:0] cnt_q;

	logic [CB+1:0] rem_n, trial;
	logic          fit;

	// bring down the next two bits; try root*4+1
	assign rem_n = {rem_q[CB-1:0], sh_q[SW-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign fit   = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= NW'(CB);
		else if (cnt_q != '0)
			cnt_q <= cnt_q - NW'(1);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= sq;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q   <= {sh_q[SW-3:0], 2'b00};
			rem_q  <= fit ? (rem_n - trial) : rem_n;
			root_q <= {root_q[CB-2:0], fit};
		end
	end

	assign root = root_q;
	assign rem  = rem_q;
	assign done = (cnt_q == '0);

endmodule

`default_nettype wire

[rtl/core/mbr_back.sv]
// Back end: per-mesh square roots, rounding and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module mbr_back #(
	parameter int CB = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mbr_pkg::snap_bits(CB)-1:0]  snap_data,
	input  logic                               snap_empty,
	output logic                               snap_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [CB-1:0]               box_min_x,
	output logic signed [CB-1:0]               box_max_x,
	output logic signed [CB-1:0]               box_min_y,
	output logic signed [CB-1:0]               box_max_y,
	output logic signed [CB-1:0]               box_min_z,
	output logic signed [CB-1:0]               box_max_z,
	output logic signed [CB-1:0]               cylinder_radius,
	output logic signed [CB-1:0]               sphere_radius
);
	import mbr_pkg::*;

	localparam int SNW = snap_bits(CB);
	localparam int BW  = 6 * CB;
	localparam int PW  = CB + 8;

	bk_state_t state_q, state_d;
	logic      start, load_out;

	logic [BW-1:0]   box_q, out_box_q;
	logic [CB-1:0]   cyl_root, sph_root, cyl_rad_q, sph_rad_q;
	logic [CB+1:0]   cyl_rem, sph_rem;
	logic            cyl_done, sph_done;
	logic            out_valid_q;

	function automatic logic [CB-1:0] round_up(input logic [CB-1:0] r,
	                                           input logic [CB+1:0] rm);
		logic [PW-1:0] scaled;
		scaled = PW'(rm) * PW'(RND_SCALE);
		// wraps at the top, as the result field does
		return r + CB'(scaled > PW'(r));
	endfunction

	mbr_isqrt #(.CB(CB)) u_cyl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sq     (snap_data[4*CB-1 -: 2*CB]),
		.root   (cyl_root),
		.rem    (cyl_rem),
		.done   (cyl_done)
	);

	mbr_isqrt #(.CB(CB)) u_sph (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sq     (snap_data[2*CB-1:0]),
		.root   (sph_root),
		.rem    (sph_rem),
		.done   (sph_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		snap_pop = 1'b0;
		start    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!snap_empty) begin
					snap_pop = 1'b1;
					start    = 1'b1;
					state_d  = BK_ROOT;
				end
			end
			BK_ROOT: begin
				if (cyl_done && sph_done)
					state_d = BK_FIN;
			end
			BK_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (snap_pop)
			box_q <= snap_data[SNW-1 -: BW];
		if (load_out) begin
			out_box_q <= box_q;
			cyl_rad_q <= round_up(cyl_root, cyl_rem);
			sph_rad_q <= round_up(sph_root, sph_rem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= load_out || (out_valid_q && !out_ready);
	end

	assign out_valid       = out_valid_q;
	assign box_min_x       = out_box_q[6*CB-1 -: CB];
	assign box_max_x       = out_box_q[5*CB-1 -: CB];
	assign box_min_y       = out_box_q[4*CB-1 -: CB];
	assign box_max_y       = out_box_q[3*CB-1 -: CB];
	assign box_min_z       = out_box_q[2*CB-1 -: CB];
	assign box_max_z       = out_box_q[CB-1:0];
	assign cylinder_radius = cyl_rad_q;
	assign sphere_radius   = sph_rad_q;

endmodule

`default_nettype wire

[rtl/core/mesh_bounds_and_radii.sv]
// A last vertex passes s1 and s2, the snapshot queue, the back end's bit-serial square
// roots (one mesh at a time) and output register; two finished meshes can queue ahead.
// Throughput: one vertex per cycle unless a finished mesh meets a full queue.
// Reset: arst_n clears the pipeline valids, the accumulators to an empty box,
// the queue and the back-end state machine; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module mesh_bounds_and_radii #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	input  logic                        last_vertex,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_max_y,
	output logic signed [COORD_BITS-1:0] box_min_z,
	output logic signed [COORD_BITS-1:0] box_max_z,
	output logic signed [COORD_BITS-1:0] cylinder_radius,
	output logic signed [COORD_BITS-1:0] sphere_radius
);
	import mbr_pkg::*;

	localparam int SNAP_W = snap_bits(COORD_BITS);

	logic              snap_push, snap_full, snap_pop, snap_empty;
	logic [SNAP_W-1:0] snap_in, snap_out;

	mbr_front #(.CB(COORD_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.last_vertex (last_vertex),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.snap_push   (snap_push),
		.snap_data   (snap_in),
		.snap_full   (snap_full)
	);

	mbr_queue #(.W(SNAP_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (snap_push),
		.din    (snap_in),
		.full   (snap_full),
		.pop    (snap_pop),
		.dout   (snap_out),
		.empty  (snap_empty)
	);

	mbr_back #(.CB(COORD_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.snap_data       (snap_out),
		.snap_empty      (snap_empty),
		.snap_pop        (snap_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.box_min_x       (box_min_x),
		.box_max_x       (box_max_x),
		.box_min_y       (box_min_y),
		.box_max_y       (box_max_y),
		.box_min_z       (box_min_z),
		.box_max_z       (box_max_z),
		.cylinder_radius (cylinder_radius),
		.sphere_radius   (sphere_radius)
	);

endmodule

`default_nettype wire

[sim/mesh_bounds_and_radii_tb.sv]
// Self-checking testbench for mesh_bounds_and_radii: streams vertex meshes and checks box and radii.
`timescale 1ns / 1ps

module mesh_bounds_and_radii_tb;

	localparam int CB = 16;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_ITEMS = 50;
	localparam int RANDOM_ITEMS = 535;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic                 last;
		logic                 wait_drain;
	} vertex_t;

	typedef struct {
		logic signed [CB-1:0] min_x;
		logic signed [CB-1:0] max_x;
		logic signed [CB-1:0] min_y;
		logic signed [CB-1:0] max_y;
		logic signed [CB-1:0] min_z;
		logic signed [CB-1:0] max_z;
		logic signed [CB-1:0] cyl;
		logic signed [CB-1:0] sph;
	} bounds_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] coord_x = '0;
	logic signed [CB-1:0] coord_y = '0;
	logic signed [CB-1:0] coord_z = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CB-1:0] box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z;
	logic signed [CB-1:0] cylinder_radius, sphere_radius;

	mesh_bounds_and_radii #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.box_min_x(box_min_x),
		.box_max_x(box_max_x),
		.box_min_y(box_min_y),
		.box_max_y(box_max_y),
		.box_min_z(box_min_z),
		.box_max_z(box_max_z),
		.cylinder_radius(cylinder_radius),
		.sphere_radius(sphere_radius)
	);

	always #5 clk = ~clk;

	vertex_t vertex_queue[$];
	bounds_t bounds_due[$];
	int mismatches = 0;
	logic calm_tail = 1'b0;

	// running mesh state, mirrors the block's accumulators
	logic signed [CB-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	longint unsigned widest_sq, furthest_sq;

	task automatic clear_mesh();
		lo_x = {1'b0, {(CB-1){1'b1}}};
		lo_y = lo_x;
		lo_z = lo_x;
		hi_x = {1'b1, {(CB-1){1'b0}}};
		hi_y = hi_x;
		hi_z = hi_x;
		widest_sq = 0;
		furthest_sq = 0;
	endtask

	function automatic longint unsigned root_floor(input longint unsigned s);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 17;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= s)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// floor(sqrt(s) + 0.99) in integers, wrapped to the coordinate width
	function automatic logic signed [CB-1:0] round_radius(input longint unsigned s);
		longint unsigned r, step;
		r = root_floor(s);
		step = 100 * r + 1;
		if (s > r * r && 10000 * s >= step * step)
			r = r + 1;
		return r[CB-1:0];
	endfunction

	task automatic absorb_vertex(input vertex_t v);
		longint sx, sy, sz;
		longint unsigned across, whole;
		bounds_t res;
		sx = v.x;
		sy = v.y;
		sz = v.z;
		if (v.x < lo_x) lo_x = v.x;
		if (v.x > hi_x) hi_x = v.x;
		if (v.y < lo_y) lo_y = v.y;
		if (v.y > hi_y) hi_y = v.y;
		if (v.z < lo_z) lo_z = v.z;
		if (v.z > hi_z) hi_z = v.z;
		across = sx * sx + sz * sz;
		whole = across + sy * sy;
		if (across > widest_sq) widest_sq = across;
		if (whole > furthest_sq) furthest_sq = whole;
		if (v.last) begin
			res.min_x = lo_x;
			res.max_x = hi_x;
			res.min_y = lo_y;
			res.max_y = hi_y;
			res.min_z = lo_z;
			res.max_z = hi_z;
			res.cyl = round_radius(widest_sq);
			res.sph = round_radius(furthest_sq);
			bounds_due.push_back(res);
			clear_mesh();
		end
	endtask

	task automatic add_vertex(input int x, input int y, input int z, input bit last,
			input bit drain);
		vertex_t v;
		v.x = x[CB-1:0];
		v.y = y[CB-1:0];
		v.z = z[CB-1:0];
		v.last = last;
		v.wait_drain = drain;
		vertex_queue.push_back(v);
	endtask

	function automatic int pick_coord();
		int t;
		case ($urandom_range(9))
			0: t = -32768;
			1: t = 32767;
			2, 3, 4: begin
				t = $urandom_range(40);
				t = t - 20;
			end
			default: t = $signed($urandom() & 32'hffff) - 32768;
		endcase
		return t;
	endfunction

	task automatic check_field(input string name, input logic signed [CB-1:0] want,
			input logic signed [CB-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// sender side
	int send_gap = 0;
	bit send_quiet = 1'b0;

	always @(posedge clk) begin
		bit take;
		if (arst_n) begin
			take = in_valid && in_ready;
			if (take) begin
				absorb_vertex(vertex_queue.pop_front());
				if ($urandom_range(39) == 0)
					send_quiet = !send_quiet;
				if (!send_quiet && !calm_tail && $urandom_range(4) == 0)
					send_gap = $urandom_range(1, 13);
			end else if (!in_valid && send_gap != 0) begin
				send_gap--;
			end
			if (!in_valid || take) begin
				if (send_gap == 0 && vertex_queue.size() != 0 &&
						(!vertex_queue[0].wait_drain || bounds_due.size() == 0)) begin
					in_valid <= 1'b1;
					coord_x <= vertex_queue[0].x;
					coord_y <= vertex_queue[0].y;
					coord_z <= vertex_queue[0].z;
					last_vertex <= vertex_queue[0].last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			calm_tail <= vertex_queue.size() < TAIL_ITEMS;
		end
	end

	// receiver side
	int recv_gap = 0;
	int hold_left = 0;
	int meshes_done = 0;
	bit long_hold_done = 1'b0;
	bit recv_quiet = 1'b0;

	always @(posedge clk) begin
		bounds_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (bounds_due.size() == 0) begin
					$error("result beat with no mesh outstanding");
					mismatches++;
				end else begin
					want = bounds_due.pop_front();
					check_field("box_min_x", want.min_x, box_min_x);
					check_field("box_max_x", want.max_x, box_max_x);
					check_field("box_min_y", want.min_y, box_min_y);
					check_field("box_max_y", want.max_y, box_max_y);
					check_field("box_min_z", want.min_z, box_min_z);
					check_field("box_max_z", want.max_z, box_max_z);
					check_field("cylinder_radius", want.cyl, cylinder_radius);
					check_field("sphere_radius", want.sph, sphere_radius);
				end
				meshes_done++;
				if ($urandom_range(15) == 0)
					recv_quiet = !recv_quiet;
			end
			// one long back-pressure stretch so the input side fills and stalls
			if (meshes_done == 8 && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = 250;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!recv_quiet && !calm_tail && $urandom_range(6) == 0)
					recv_gap = $urandom_range(1, 13);
			end
		end
	end

	// watchdog: cycles without any beat on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int added, mesh_len, mesh_count;
		clear_mesh();

		// single-vertex meshes at the origin and the corners
		add_vertex(0, 0, 0, 1, 0);
		add_vertex(-32768, -32768, -32768, 1, 0);  // sphere radius wraps
		add_vertex(32767, 32767, 32767, 1, 0);
		add_vertex(32767, -32768, 0, 0, 0);
		add_vertex(-32768, 32767, -1, 0, 0);
		add_vertex(1, 1, 32767, 1, 0);
		// exact squares
		add_vertex(3, 4, 0, 0, 0);
		add_vertex(3, 0, 4, 1, 0);
		// largest square early, small final vertex; 10001 just misses round-up
		add_vertex(100, 0, 1, 0, 0);
		add_vertex(1, 1, 0, 1, 0);
		add_vertex(-1, -1, -1, 0, 0);
		add_vertex(1, 1, 1, 0, 0);
		add_vertex(0, 0, 0, 1, 0);
		add_vertex(-32768, 0, -32768, 1, 0);  // cylinder radius wraps
		add_vertex(20000, -20000, 20000, 1, 0);

		added = 0;
		mesh_count = 0;
		while (added < RANDOM_ITEMS) begin
			if ($urandom_range(14) == 0)
				mesh_len = $urandom_range(15, 40);
			else
				mesh_len = $urandom_range(1, 6);
			for (int i = 0; i < mesh_len; i++)
				add_vertex(pick_coord(), pick_coord(), pick_coord(), i == mesh_len - 1,
					i == 0 && (mesh_count == 0 || mesh_count == 40));
			added += mesh_len;
			mesh_count++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (vertex_queue.size() == 0);
		wait (bounds_due.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
rtl/core/mbr_pkg.sv
rtl/core/mbr_front.sv
rtl/core/mbr_queue.sv
rtl/core/mbr_isqrt.sv
rtl/core/mbr_back.sv
rtl/core/mesh_bounds_and_radii.sv
sim/mesh_bounds_and_radii_tb.sv
